// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the EXI event code decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/exi_ecd_pkg.sv =====
// Shared types and codes for the EXI built-in-grammar event code decoder.
// No dependencies; used by the register block, the decode logic and the top level.
package exi_ecd_pkg;

   localparam int WINDOW_BITS = 24;
   localparam int BYTE_BITS   = 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Register indexes (byte address is four times the index).
   localparam logic [2:0] REG_KEEP_COMMENTS       = 3'd0;
   localparam logic [2:0] REG_KEEP_PIS            = 3'd1;
   localparam logic [2:0] REG_KEEP_DTD            = 3'd2;
   localparam logic [2:0] REG_KEEP_PREFIXES       = 3'd3;
   localparam logic [2:0] REG_KEEP_SELF_CONTAINED = 3'd4;
   localparam logic [2:0] REG_BYTE_ALIGNED        = 3'd5;

   // Status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_INVALID     = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

   // Event kinds.
   localparam logic [3:0] EV_SD = 4'd0;
   localparam logic [3:0] EV_ED = 4'd1;
   localparam logic [3:0] EV_SE = 4'd2;
   localparam logic [3:0] EV_EE = 4'd3;
   localparam logic [3:0] EV_AT = 4'd4;
   localparam logic [3:0] EV_NS = 4'd5;
   localparam logic [3:0] EV_SC = 4'd6;
   localparam logic [3:0] EV_CH = 4'd7;
   localparam logic [3:0] EV_ER = 4'd8;
   localparam logic [3:0] EV_CM = 4'd9;
   localparam logic [3:0] EV_PI = 4'd10;
   localparam logic [3:0] EV_DT = 4'd11;

   // Grammar kinds.
   localparam logic [2:0] GR_DOC      = 3'd0;
   localparam logic [2:0] GR_FRAG     = 3'd1;
   localparam logic [2:0] GR_DOCCONT  = 3'd2;
   localparam logic [2:0] GR_DOCEND   = 3'd3;
   localparam logic [2:0] GR_STAG     = 3'd4;
   localparam logic [2:0] GR_ELEM     = 3'd5;
   localparam logic [2:0] GR_FRAGCONT = 3'd6;

   typedef struct packed {
      logic keep_comments;
      logic keep_pis;
      logic keep_dtd;
      logic keep_prefixes;
      logic keep_self_contained;
      logic byte_aligned;
   } cfg_type;

   typedef struct packed {
      logic [2:0]             grammar_kind;
      logic [WINDOW_BITS-1:0] lookahead;
      logic [4:0]             bits_valid;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] event_kind;
      logic [2:0] next_grammar;
      logic       push_element;
      logic       pop_grammar;
      logic [3:0] code_value;
      logic [2:0] code_width;
      logic [4:0] bits_consumed;
   } rsp_item_type;

endpackage

// ===== hw/rtl/exi_ecd_csr.sv =====
// Configuration registers of the EXI event code decoder behind an APB-style port.
// Depends on exi_ecd_pkg for the register indexes and the configuration struct.
module exi_ecd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [exi_ecd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [exi_ecd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [exi_ecd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready,
   output exi_ecd_pkg::cfg_type                cfg
);

   exi_ecd_pkg::cfg_type cfg_ff;
   exi_ecd_pkg::cfg_type cfg_in;
   logic [2:0]           reg_index;
   logic                 wr_en;
   logic                 rd_bit;

   assign reg_index  = csr_paddr[exi_ecd_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            exi_ecd_pkg::REG_KEEP_COMMENTS:       cfg_in.keep_comments       = csr_pwdata[0];
            exi_ecd_pkg::REG_KEEP_PIS:            cfg_in.keep_pis            = csr_pwdata[0];
            exi_ecd_pkg::REG_KEEP_DTD:            cfg_in.keep_dtd            = csr_pwdata[0];
            exi_ecd_pkg::REG_KEEP_PREFIXES:       cfg_in.keep_prefixes       = csr_pwdata[0];
            exi_ecd_pkg::REG_KEEP_SELF_CONTAINED: cfg_in.keep_self_contained = csr_pwdata[0];
            exi_ecd_pkg::REG_BYTE_ALIGNED:        cfg_in.byte_aligned        = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         exi_ecd_pkg::REG_KEEP_COMMENTS:       rd_bit = cfg_ff.keep_comments;
         exi_ecd_pkg::REG_KEEP_PIS:            rd_bit = cfg_ff.keep_pis;
         exi_ecd_pkg::REG_KEEP_DTD:            rd_bit = cfg_ff.keep_dtd;
         exi_ecd_pkg::REG_KEEP_PREFIXES:       rd_bit = cfg_ff.keep_prefixes;
         exi_ecd_pkg::REG_KEEP_SELF_CONTAINED: rd_bit = cfg_ff.keep_self_contained;
         exi_ecd_pkg::REG_BYTE_ALIGNED:        rd_bit = cfg_ff.byte_aligned;
         default:                              rd_bit = 1'b0;
      endcase
   end

   assign csr_prdata = {{(exi_ecd_pkg::CSR_DATA_W-1){1'b0}}, rd_bit};
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/exi_ecd_decode.sv =====
// Single-pass decode of one EXI event code from a registered lookahead window.
// Depends on exi_ecd_pkg for codes and item structs; purely combinational.
module exi_ecd_decode (
   input  exi_ecd_pkg::cfg_type      cfg,
   input  exi_ecd_pkg::req_item_type req,
   output exi_ecd_pkg::rsp_item_type rsp
);

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
      logic [2:0] w;
      logic [4:0] pos;
   } read_type;

   localparam int W = exi_ecd_pkg::WINDOW_BITS;

   // Reads one code part choosing among count productions, starting at pos.
   function automatic read_type take(input logic [W-1:0] win, input logic [4:0] avail,
                                     input logic [4:0] pos, input logic bytes,
                                     input logic [3:0] count);
      read_type              r;
      logic [W-1:0]          sh;
      logic [5:0]            end_pos;
      logic [exi_ecd_pkg::BYTE_BITS-1:0] byte_v;
      logic [3:0]            bits_v;
      logic                  cnt_ok;
      r       = '0;
      cnt_ok  = 1'b1;
      case (count)
         4'd0:                      begin r.w = 3'd0; cnt_ok = 1'b0; end
         4'd1:                      r.w = 3'd0;
         4'd2:                      r.w = 3'd1;
         4'd3, 4'd4:                r.w = 3'd2;
         4'd5, 4'd6, 4'd7, 4'd8:    r.w = 3'd3;
         default:                   r.w = 3'd4;
      endcase
      sh     = win << pos;
      byte_v = sh[W-1 -: exi_ecd_pkg::BYTE_BITS];
      bits_v = sh[W-1 -: 4] >> (3'd4 - r.w);
      r.pos  = pos;
      if (!cnt_ok) begin
         r.ok = 1'b0;
      end else if (r.w == 3'd0) begin
         r.ok = 1'b1;
      end else if (bytes) begin
         end_pos = {1'b0, pos} + 6'(exi_ecd_pkg::BYTE_BITS);
         // The byte must lie inside the window and fit the part width.
         r.ok    = (end_pos <= {1'b0, avail}) && ((byte_v >> r.w) == '0);
         r.val   = byte_v[3:0];
         r.pos   = end_pos[4:0];
      end else begin
         end_pos = {1'b0, pos} + {3'b000, r.w};
         r.ok    = end_pos <= {1'b0, avail};
         r.val   = bits_v;
         r.pos   = end_pos[4:0];
      end
      return r;
   endfunction

   logic       c, pi, d;
   logic [4:0] avail;
   read_type   r1, r2, r3;
   logic [1:0] st;
   logic [3:0] ev;
   logic [2:0] nxt;
   logic       push, pop;
   logic [3:0] val;
   logic [2:0] wsum;
   logic [4:0] pos;
   logic [3:0] s, cur;
   logic       tail, hit;

   assign c  = cfg.keep_comments;
   assign pi = cfg.keep_pis;
   assign d  = cfg.keep_dtd;
   assign avail = (req.bits_valid > 5'(W)) ? 5'(W) : req.bits_valid;

   always_comb begin
      r1   = '0;
      r2   = '0;
      r3   = '0;
      st   = exi_ecd_pkg::ST_OK;
      ev   = exi_ecd_pkg::EV_SD;
      nxt  = exi_ecd_pkg::GR_DOC;
      push = 1'b0;
      pop  = 1'b0;
      val  = 4'd0;
      wsum = 3'd0;
      pos  = 5'd0;
      s    = 4'd0;
      cur  = 4'd0;
      tail = 1'b0;
      hit  = 1'b0;
      case (req.grammar_kind)
         exi_ecd_pkg::GR_DOC: begin
            nxt = exi_ecd_pkg::GR_DOCCONT;
         end
         exi_ecd_pkg::GR_FRAG: begin
            nxt = exi_ecd_pkg::GR_FRAGCONT;
         end
         exi_ecd_pkg::GR_DOCCONT: begin
            if (!d && !c && !pi) begin
               ev = exi_ecd_pkg::EV_SE; nxt = exi_ecd_pkg::GR_DOCEND; push = 1'b1;
            end else begin
               r1   = take(req.lookahead, avail, 5'd0, cfg.byte_aligned, 4'd2);
               wsum = r1.w;
               pos  = r1.pos;
               val  = r1.val;
               if (!r1.ok) begin
                  st = exi_ecd_pkg::ST_INVALID;
               end else if (r1.val == 4'd0) begin
                  ev = exi_ecd_pkg::EV_SE; nxt = exi_ecd_pkg::GR_DOCEND; push = 1'b1;
               end else begin
                  r2   = take(req.lookahead, avail, r1.pos, cfg.byte_aligned,
                              {3'b000, d} + {3'b000, c | pi});
                  wsum = wsum + r2.w;
                  pos  = r2.pos;
                  if (!r2.ok) begin
                     st = exi_ecd_pkg::ST_INVALID;
                  end else if (d && r2.val == 4'd0) begin
                     ev = exi_ecd_pkg::EV_DT; nxt = exi_ecd_pkg::GR_DOCCONT;
                  end else if (!(c | pi) || r2.val != {3'b000, d}) begin
                     st = exi_ecd_pkg::ST_INVALID;
                  end else begin
                     r3   = take(req.lookahead, avail, r2.pos, cfg.byte_aligned,
                                 {3'b000, c} + {3'b000, pi});
                     wsum = wsum + r3.w;
                     pos  = r3.pos;
                     if (!r3.ok) begin
                        st = exi_ecd_pkg::ST_INVALID;
                     end else if (c && r3.val == 4'd0) begin
                        ev = exi_ecd_pkg::EV_CM; nxt = exi_ecd_pkg::GR_DOCCONT;
                     end else if (pi && r3.val == {3'b000, c}) begin
                        ev = exi_ecd_pkg::EV_PI; nxt = exi_ecd_pkg::GR_DOCCONT;
                     end else begin
                        st = exi_ecd_pkg::ST_INVALID;
                     end
                  end
               end
            end
         end
         exi_ecd_pkg::GR_DOCEND: begin
            if (!c && !pi) begin
               ev = exi_ecd_pkg::EV_ED; nxt = exi_ecd_pkg::GR_DOCEND; pop = 1'b1;
            end else begin
               r1   = take(req.lookahead, avail, 5'd0, cfg.byte_aligned, 4'd2);
               wsum = r1.w;
               pos  = r1.pos;
               val  = r1.val;
               if (!r1.ok) begin
                  st = exi_ecd_pkg::ST_INVALID;
               end else if (r1.val == 4'd0) begin
                  ev = exi_ecd_pkg::EV_ED; nxt = exi_ecd_pkg::GR_DOCEND; pop = 1'b1;
               end else begin
                  r2   = take(req.lookahead, avail, r1.pos, cfg.byte_aligned,
                              {3'b000, c} + {3'b000, pi});
                  wsum = wsum + r2.w;
                  pos  = r2.pos;
                  if (!r2.ok) begin
                     st = exi_ecd_pkg::ST_INVALID;
                  end else if (c && r2.val == 4'd0) begin
                     ev = exi_ecd_pkg::EV_CM; nxt = exi_ecd_pkg::GR_DOCEND;
                  end else if (pi && r2.val == {3'b000, c}) begin
                     ev = exi_ecd_pkg::EV_PI; nxt = exi_ecd_pkg::GR_DOCEND;
                  end else begin
                     st = exi_ecd_pkg::ST_INVALID;
                  end
               end
            end
         end
         exi_ecd_pkg::GR_STAG: begin
            r1   = take(req.lookahead, avail, 5'd0, cfg.byte_aligned,
                        4'd4 + {3'b000, cfg.keep_prefixes} + {3'b000, cfg.keep_self_contained}
                        + {3'b000, d} + {3'b000, c} + {3'b000, pi});
            wsum = r1.w;
            pos  = r1.pos;
            val  = r1.val;
            s    = r1.val;
            if (!r1.ok) begin
               st = exi_ecd_pkg::ST_INVALID;
            end else if (s == 4'd0) begin
               ev = exi_ecd_pkg::EV_EE; nxt = exi_ecd_pkg::GR_STAG; pop = 1'b1;
            end else if (s == 4'd1) begin
               ev = exi_ecd_pkg::EV_AT; nxt = exi_ecd_pkg::GR_STAG;
            end else begin
               cur = 4'd2;
               if (cfg.keep_prefixes) begin
                  if (s == cur) begin
                     hit = 1'b1; ev = exi_ecd_pkg::EV_NS; nxt = exi_ecd_pkg::GR_STAG;
                  end
                  cur = cur + 4'd1;
               end
               if (cfg.keep_self_contained && !hit) begin
                  if (s == cur) begin
                     hit = 1'b1; ev = exi_ecd_pkg::EV_SC; nxt = exi_ecd_pkg::GR_STAG;
                  end
                  cur = cur + 4'd1;
               end
               tail = !hit;
            end
         end
         exi_ecd_pkg::GR_ELEM: begin
            r1   = take(req.lookahead, avail, 5'd0, cfg.byte_aligned, 4'd2);
            wsum = r1.w;
            pos  = r1.pos;
            val  = r1.val;
            if (!r1.ok) begin
               st = exi_ecd_pkg::ST_INVALID;
            end else if (r1.val == 4'd0) begin
               ev = exi_ecd_pkg::EV_EE; nxt = exi_ecd_pkg::GR_ELEM; pop = 1'b1;
            end else begin
               r2   = take(req.lookahead, avail, r1.pos, cfg.byte_aligned,
                           4'd2 + {3'b000, d} + {3'b000, c} + {3'b000, pi});
               wsum = wsum + r2.w;
               pos  = r2.pos;
               s    = r2.val;
               if (!r2.ok) begin
                  st = exi_ecd_pkg::ST_INVALID;
               end else begin
                  tail = 1'b1;
               end
            end
         end
         default: begin
            st = exi_ecd_pkg::ST_UNSUPPORTED;
         end
      endcase

      // Element content productions shared by start tag and element grammars.
      if (tail) begin
         nxt = exi_ecd_pkg::GR_ELEM;
         hit = 1'b0;
         if (s == cur) begin
            hit = 1'b1; ev = exi_ecd_pkg::EV_SE; push = 1'b1;
         end else if (s == cur + 4'd1) begin
            hit = 1'b1; ev = exi_ecd_pkg::EV_CH;
         end
         cur = cur + 4'd2;
         if (d && !hit) begin
            if (s == cur) begin
               hit = 1'b1; ev = exi_ecd_pkg::EV_ER;
            end
            cur = cur + 4'd1;
         end
         if (c && !hit) begin
            if (s == cur) begin
               hit = 1'b1; ev = exi_ecd_pkg::EV_CM;
            end
            cur = cur + 4'd1;
         end
         if (pi && !hit && s == cur) begin
            hit = 1'b1; ev = exi_ecd_pkg::EV_PI;
         end
         if (!hit) begin
            st = exi_ecd_pkg::ST_INVALID;
         end
      end
   end

   always_comb begin
      rsp        = '0;
      rsp.status = st;
      if (st == exi_ecd_pkg::ST_OK) begin
         rsp.event_kind    = ev;
         rsp.next_grammar  = nxt;
         rsp.push_element  = push;
         rsp.pop_grammar   = pop;
         rsp.code_value    = val;
         rsp.code_width    = wsum;
         rsp.bits_consumed = pos;
      end
   end

endmodule

// ===== hw/rtl/exi_event_code_decoder.sv =====
// EXI built-in-grammar event code decoder.
//
// Request channel (req_*): one request per event code, carrying the current
// grammar, a 24-bit lookahead window with the earliest stream bit on top, and
// the count of valid bits. Response channel (rsp_*): one response per request
// with status, event kind, next grammar, stack flags, first code part value,
// total code width and stream bits consumed. On any failure every field but
// status is zero.
// Configuration (csr_*): six one-bit registers at byte addresses 0 to 20 for
// the fidelity options and byte-aligned mode. Write them only while no request
// is in flight.
// A request lands in the input register, the decode is one pass of
// combinational logic, and the answer sits in the response register.
// Throughput is one request per cycle while the receiver takes responses, set
// by that single decode pass. When the receiver stalls, the response register
// holds and the input register keeps one more request, then req_tready drops.
// Reset clears the option registers and both valid flags, which empties the
// two pipeline stages; the data registers keep their contents.
// Depends on exi_ecd_pkg, exi_ecd_csr, exi_ecd_decode and assert_macros.svh.
`include "assert_macros.svh"

module exi_event_code_decoder (
   input  logic                               clock,
   input  logic                               reset,
   // Request tdata, from bit 0: grammar_kind[2:0], lookahead[23:0], bits_valid[4:0].
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,
   // Response tdata, from bit 0: status[1:0], event_kind[3:0], next_grammar[2:0],
   // push_element, pop_grammar, code_value[3:0], code_width[2:0], bits_consumed[4:0],
   // then one zero pad bit.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [exi_ecd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [exi_ecd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [exi_ecd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int W = exi_ecd_pkg::WINDOW_BITS;

   exi_ecd_pkg::cfg_type      cfg;
   exi_ecd_pkg::req_item_type req_item;
   exi_ecd_pkg::req_item_type req_data_ff, req_data_in;
   logic                      req_valid_ff, req_valid_in;
   exi_ecd_pkg::rsp_item_type dec_rsp;
   exi_ecd_pkg::rsp_item_type rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;
   logic                      req_take;

   exi_ecd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   exi_ecd_decode u_decode (
      .cfg (cfg),
      .req (req_data_ff),
      .rsp (dec_rsp)
   );

   assign req_item.grammar_kind = req_tdata[2:0];
   assign req_item.lookahead    = req_tdata[W+2:3];
   assign req_item.bits_valid   = req_tdata[W+7:W+3];

   // The response register loads whenever it is empty or being drained.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || rsp_load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      req_data_in  = req_data_ff;
      req_valid_in = req_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_data_in  = dec_rsp;
         rsp_valid_in = req_valid_ff;
      end
      if (req_tready) begin
         req_data_in  = req_item;
         req_valid_in = req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.bits_consumed,
                        rsp_data_ff.code_width,
                        rsp_data_ff.code_value,
                        rsp_data_ff.pop_grammar,
                        rsp_data_ff.push_element,
                        rsp_data_ff.next_grammar,
                        rsp_data_ff.event_kind,
                        rsp_data_ff.status};

   `ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, req_valid_ff)

   `ASSERT_IMPLIES(a_fail_clears, clock, reset,
      rsp_valid_ff && rsp_data_ff.status != exi_ecd_pkg::ST_OK,
      rsp_data_ff.event_kind == 4'd0 && rsp_data_ff.next_grammar == 3'd0 &&
      !rsp_data_ff.push_element && !rsp_data_ff.pop_grammar &&
      rsp_data_ff.code_value == 4'd0 && rsp_data_ff.code_width == 3'd0 &&
      rsp_data_ff.bits_consumed == 5'd0)

   `ASSERT_IMPLIES(a_bit_mode_width, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == exi_ecd_pkg::ST_OK && !cfg.byte_aligned,
      rsp_data_ff.bits_consumed == 5'(rsp_data_ff.code_width))

   `ASSERT_IMPLIES(a_byte_mode_whole, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == exi_ecd_pkg::ST_OK && cfg.byte_aligned,
      rsp_data_ff.bits_consumed[2:0] == 3'd0)

endmodule

// ===== tb/exi_event_code_decoder_tb.sv =====
// Self-checking testbench for the EXI built-in-grammar event code decoder.
// Depends on exi_ecd_pkg and the exi_event_code_decoder RTL; needs no other files.
`timescale 1ns / 100ps

module exi_event_code_decoder_tb;

   // Grammar code 7 is outside the defined grammars.
   localparam logic [2:0] GR_UNDEFINED = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 4;

   typedef struct {
      logic [1:0] status;
      logic [3:0] kind;
      logic [2:0] next_gr;
      logic       push;
      logic       pop;
      logic [3:0] value;
      logic [2:0] width;
      logic [4:0] consumed;
   } event_code_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // req_tdata, from bit 0: grammar_kind[2:0], lookahead[23:0], bits_valid[4:0].
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   // rsp_tdata, from bit 0: status[1:0], event_kind[3:0], next_grammar[2:0],
   // push_element, pop_grammar, code_value[3:0], code_width[2:0],
   // bits_consumed[4:0], one zero pad bit.
   logic [23:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [exi_ecd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [exi_ecd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [exi_ecd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the option registers.
   bit keep_cm, keep_pi, keep_dt, keep_ns, keep_sc, byte_mode;

   event_code_type pending_events[$];
   int          error_count = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;
   bit          idling_on = 1'b1;

   exi_event_code_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Reads one code part that chooses among count productions.
   function automatic bit read_code_part(input int unsigned count, input logic [23:0] look,
                                         input int unsigned avail, inout int unsigned pos,
                                         inout int unsigned wsum, output int unsigned val);
      int unsigned w;
      int unsigned slots;
      val = 0;
      if (count == 0) return 1'b0;
      w = 0;
      slots = 1;
      while (slots < count) begin
         slots = slots << 1;
         w++;
      end
      wsum += w;
      if (w == 0) return 1'b1;
      if (byte_mode) begin
         if (pos + 8 > avail) return 1'b0;
         val = (look >> (exi_ecd_pkg::WINDOW_BITS - pos - 8)) & 32'hFF;
         // A byte that does not fit the part width is rejected.
         if (val >= (32'd1 << w)) return 1'b0;
         pos += 8;
      end else begin
         if (pos + w > avail) return 1'b0;
         val = (look >> (exi_ecd_pkg::WINDOW_BITS - pos - w)) & ((32'd1 << w) - 1);
         pos += w;
      end
      return 1'b1;
   endfunction

   function automatic event_code_type production(logic [3:0] kind, logic [2:0] next_gr,
                                                 int unsigned push, int unsigned pop,
                                                 int unsigned val, int unsigned wsum,
                                                 int unsigned pos);
      event_code_type ev;
      ev.status   = exi_ecd_pkg::ST_OK;
      ev.kind     = kind;
      ev.next_gr  = next_gr;
      ev.push     = push[0];
      ev.pop      = pop[0];
      ev.value    = val[3:0];
      ev.width    = wsum[2:0];
      ev.consumed = pos[4:0];
      return ev;
   endfunction

   function automatic event_code_type decode_event_code(logic [2:0] grammar,
                                                        logic [23:0] look,
                                                        logic [4:0] nbits);
      event_code_type bad;
      int unsigned avail, pos, wsum, val, s, t, cur;
      int unsigned c, p, d;
      bad = '{default: '0};
      bad.status = exi_ecd_pkg::ST_INVALID;
      avail = (nbits > exi_ecd_pkg::WINDOW_BITS) ? exi_ecd_pkg::WINDOW_BITS : 32'(nbits);
      pos = 0;
      wsum = 0;
      val = 0;
      s = 0;
      t = 0;
      cur = 0;
      c = 32'(keep_cm);
      p = 32'(keep_pi);
      d = 32'(keep_dt);
      case (grammar)
         exi_ecd_pkg::GR_DOC:
            return production(exi_ecd_pkg::EV_SD, exi_ecd_pkg::GR_DOCCONT, 0, 0, 0, 0, 0);
         exi_ecd_pkg::GR_FRAG:
            return production(exi_ecd_pkg::EV_SD, exi_ecd_pkg::GR_FRAGCONT, 0, 0, 0, 0, 0);
         exi_ecd_pkg::GR_DOCCONT: begin
            if (d == 0 && c == 0 && p == 0)
               return production(exi_ecd_pkg::EV_SE, exi_ecd_pkg::GR_DOCEND, 1, 0, 0, 0, 0);
            if (!read_code_part(2, look, avail, pos, wsum, val)) return bad;
            if (val == 0)
               return production(exi_ecd_pkg::EV_SE, exi_ecd_pkg::GR_DOCEND, 1, 0,
                                 val, wsum, pos);
            if (!read_code_part(d + ((c | p) ? 1 : 0), look, avail, pos, wsum, s)) return bad;
            if (d != 0 && s == 0)
               return production(exi_ecd_pkg::EV_DT, exi_ecd_pkg::GR_DOCCONT, 0, 0,
                                 val, wsum, pos);
            if ((c | p) == 0 || s != d) return bad;
            if (!read_code_part(c + p, look, avail, pos, wsum, t)) return bad;
            if (c != 0 && t == 0)
               return production(exi_ecd_pkg::EV_CM, exi_ecd_pkg::GR_DOCCONT, 0, 0,
                                 val, wsum, pos);
            if (p != 0 && t == c)
               return production(exi_ecd_pkg::EV_PI, exi_ecd_pkg::GR_DOCCONT, 0, 0,
                                 val, wsum, pos);
            return bad;
         end
         exi_ecd_pkg::GR_DOCEND: begin
            if (c == 0 && p == 0)
               return production(exi_ecd_pkg::EV_ED, exi_ecd_pkg::GR_DOCEND, 0, 1, 0, 0, 0);
            if (!read_code_part(2, look, avail, pos, wsum, val)) return bad;
            if (val == 0)
               return production(exi_ecd_pkg::EV_ED, exi_ecd_pkg::GR_DOCEND, 0, 1,
                                 val, wsum, pos);
            if (!read_code_part(c + p, look, avail, pos, wsum, s)) return bad;
            if (c != 0 && s == 0)
               return production(exi_ecd_pkg::EV_CM, exi_ecd_pkg::GR_DOCEND, 0, 0,
                                 val, wsum, pos);
            if (p != 0 && s == c)
               return production(exi_ecd_pkg::EV_PI, exi_ecd_pkg::GR_DOCEND, 0, 0,
                                 val, wsum, pos);
            return bad;
         end
         exi_ecd_pkg::GR_STAG: begin
            if (!read_code_part(4 + keep_ns + keep_sc + d + c + p, look, avail, pos, wsum, val))
               return bad;
            s = val;
            if (s == 0)
               return production(exi_ecd_pkg::EV_EE, exi_ecd_pkg::GR_STAG, 0, 1,
                                 val, wsum, pos);
            if (s == 1)
               return production(exi_ecd_pkg::EV_AT, exi_ecd_pkg::GR_STAG, 0, 0,
                                 val, wsum, pos);
            cur = 2;
            if (keep_ns) begin
               if (s == cur)
                  return production(exi_ecd_pkg::EV_NS, exi_ecd_pkg::GR_STAG, 0, 0,
                                    val, wsum, pos);
               cur++;
            end
            if (keep_sc) begin
               if (s == cur)
                  return production(exi_ecd_pkg::EV_SC, exi_ecd_pkg::GR_STAG, 0, 0,
                                    val, wsum, pos);
               cur++;
            end
         end
         exi_ecd_pkg::GR_ELEM: begin
            if (!read_code_part(2, look, avail, pos, wsum, val)) return bad;
            if (val == 0)
               return production(exi_ecd_pkg::EV_EE, exi_ecd_pkg::GR_ELEM, 0, 1,
                                 val, wsum, pos);
            if (!read_code_part(2 + d + c + p, look, avail, pos, wsum, s)) return bad;
            cur = 0;
         end
         default: begin
            bad.status = exi_ecd_pkg::ST_UNSUPPORTED;
            return bad;
         end
      endcase
      // Element content shared by start tag and element grammars.
      if (s == cur)
         return production(exi_ecd_pkg::EV_SE, exi_ecd_pkg::GR_ELEM, 1, 0, val, wsum, pos);
      cur++;
      if (s == cur)
         return production(exi_ecd_pkg::EV_CH, exi_ecd_pkg::GR_ELEM, 0, 0, val, wsum, pos);
      cur++;
      if (d != 0) begin
         if (s == cur)
            return production(exi_ecd_pkg::EV_ER, exi_ecd_pkg::GR_ELEM, 0, 0, val, wsum, pos);
         cur++;
      end
      if (c != 0) begin
         if (s == cur)
            return production(exi_ecd_pkg::EV_CM, exi_ecd_pkg::GR_ELEM, 0, 0, val, wsum, pos);
         cur++;
      end
      if (p != 0 && s == cur)
         return production(exi_ecd_pkg::EV_PI, exi_ecd_pkg::GR_ELEM, 0, 0, val, wsum, pos);
      return bad;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response checker and receiver stall generator.
   always @(posedge clock) begin
      event_code_type got;
      event_code_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = rsp_tdata[1:0];
         got.kind     = rsp_tdata[5:2];
         got.next_gr  = rsp_tdata[8:6];
         got.push     = rsp_tdata[9];
         got.pop      = rsp_tdata[10];
         got.value    = rsp_tdata[14:11];
         got.width    = rsp_tdata[17:15];
         got.consumed = rsp_tdata[22:18];
         if (pending_events.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("event_kind", 32'(want.kind), 32'(got.kind));
            check_field("next_grammar", 32'(want.next_gr), 32'(got.next_gr));
            check_field("push_element", 32'(want.push), 32'(got.push));
            check_field("pop_grammar", 32'(want.pop), 32'(got.pop));
            check_field("code_value", 32'(want.value), 32'(got.value));
            check_field("code_width", 32'(want.width), 32'(got.width));
            check_field("bits_consumed", 32'(want.consumed), 32'(got.consumed));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(1, 14)) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles in which no request, response or register write moves.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] index, bit value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         exi_ecd_pkg::REG_KEEP_COMMENTS:       keep_cm = value;
         exi_ecd_pkg::REG_KEEP_PIS:            keep_pi = value;
         exi_ecd_pkg::REG_KEEP_DTD:            keep_dt = value;
         exi_ecd_pkg::REG_KEEP_PREFIXES:       keep_ns = value;
         exi_ecd_pkg::REG_KEEP_SELF_CONTAINED: keep_sc = value;
         exi_ecd_pkg::REG_BYTE_ALIGNED:        byte_mode = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Bit i of opts goes to the register with index i.
   task automatic apply_config(bit [5:0] opts);
      csr_write(exi_ecd_pkg::REG_KEEP_COMMENTS, opts[0]);
      csr_write(exi_ecd_pkg::REG_KEEP_PIS, opts[1]);
      csr_write(exi_ecd_pkg::REG_KEEP_DTD, opts[2]);
      csr_write(exi_ecd_pkg::REG_KEEP_PREFIXES, opts[3]);
      csr_write(exi_ecd_pkg::REG_KEEP_SELF_CONTAINED, opts[4]);
      csr_write(exi_ecd_pkg::REG_BYTE_ALIGNED, opts[5]);
   endtask

   // Drops the request valid and waits until every expected response is in.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(logic [2:0] grammar, logic [23:0] look, logic [4:0] nbits);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {nbits, look, grammar};
      do @(posedge clock); while (!req_tready);
      pending_events.push_back(decode_event_code(grammar, look, nbits));
   endtask

   task automatic send_random_request();
      logic [2:0]  grammar;
      logic [23:0] look;
      logic [4:0]  nbits;
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2)
         grammar = 3'($urandom_range(exi_ecd_pkg::GR_DOC, exi_ecd_pkg::GR_FRAG));
      else if (pick < 18)
         grammar = 3'($urandom_range(exi_ecd_pkg::GR_DOCCONT, exi_ecd_pkg::GR_ELEM));
      else
         grammar = 3'($urandom_range(exi_ecd_pkg::GR_FRAGCONT, GR_UNDEFINED));
      nbits = ($urandom_range(0, 9) < 7) ? 5'd24 : 5'($urandom_range(0, 31));
      look = 24'($urandom);
      // In byte mode most windows carry small byte values so choices resolve.
      if (byte_mode && $urandom_range(0, 3) != 0) begin
         for (int i = 0; i < 3; i++) begin
            pick = $urandom_range(0, 7);
            if (pick < 4) look[23 - 8*i -: 8] = 8'($urandom_range(0, 1));
            else if (pick < 6) look[23 - 8*i -: 8] = 8'($urandom_range(0, 8));
            else if (pick == 6) look[23 - 8*i -: 8] = 8'($urandom_range(0, 15));
            else look[23 - 8*i -: 8] = 8'($urandom_range(0, 255));
         end
      end
      send_request(grammar, look, nbits);
   endtask

   task automatic test_default_grammars();
      apply_config(6'b000000);
      send_request(exi_ecd_pkg::GR_DOC, 24'hFFFFFF, 5'd24);
      send_request(exi_ecd_pkg::GR_FRAG, 24'h000000, 5'd0);
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'hFFFFFF, 5'd0);
      send_request(exi_ecd_pkg::GR_DOCEND, 24'h000000, 5'd0);
      send_request(exi_ecd_pkg::GR_STAG, 24'h000000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'h400000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'h800000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'hC00000, 5'd24);
      send_request(exi_ecd_pkg::GR_ELEM, 24'h000000, 5'd24);
      send_request(exi_ecd_pkg::GR_ELEM, 24'hC00000, 5'd2);
      // Window too short for the start tag choice.
      send_request(exi_ecd_pkg::GR_STAG, 24'hFFFFFF, 5'd1);
      send_request(exi_ecd_pkg::GR_FRAGCONT, 24'h123456, 5'd24);
      send_request(GR_UNDEFINED, 24'hFFFFFF, 5'd31);
      wait_idle();
   endtask

   task automatic test_full_fidelity_bit_packed();
      apply_config(6'b011111);
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'hC00000, 5'd24);
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'hE00000, 5'd24);
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'hF00000, 5'd24);
      send_request(exi_ecd_pkg::GR_DOCEND, 24'h800000, 5'd24);
      send_request(exi_ecd_pkg::GR_DOCEND, 24'hC00000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'h200000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'h300000, 5'd24);
      send_request(exi_ecd_pkg::GR_STAG, 24'h800000, 5'd24);
      // A value past the last production selects nothing.
      send_request(exi_ecd_pkg::GR_STAG, 24'hF00000, 5'd24);
      // Valid-bit counts above the window width are clamped.
      send_request(exi_ecd_pkg::GR_STAG, 24'h700000, 5'd31);
      send_request(exi_ecd_pkg::GR_ELEM, 24'hA00000, 5'd24);
      send_request(exi_ecd_pkg::GR_ELEM, 24'hD00000, 5'd24);
      wait_idle();
   endtask

   task automatic test_byte_aligned_reads();
      apply_config(6'b111111);
      send_request(exi_ecd_pkg::GR_STAG, 24'h080000, 5'd24);
      // The byte value does not fit the four-bit part.
      send_request(exi_ecd_pkg::GR_STAG, 24'h100000, 5'd24);
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'h010101, 5'd24);
      // Only two whole bytes are usable, the third part runs short.
      send_request(exi_ecd_pkg::GR_DOCCONT, 24'h010101, 5'd20);
      send_request(exi_ecd_pkg::GR_ELEM, 24'h010400, 5'd16);
      wait_idle();
   endtask

   task automatic test_random_decodes();
      bit [5:0] opts;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: opts = 6'b000000;
            1: opts = 6'b011111;
            2: opts = 6'b100000;
            3: opts = 6'b111111;
            default: opts = 6'($urandom);
         endcase
         apply_config(opts);
         for (int n = 0; n < 85; n++) begin
            // Now and then the sender holds off until the decoder has drained.
            if (n == 42 && phase % 4 == 1) wait_idle();
            send_random_request();
         end
         wait_idle();
      end
   endtask

   task automatic test_unthrottled_stream();
      idling_on = 1'b0;
      apply_config(6'($urandom));
      for (int n = 0; n < 230; n++) send_random_request();
      wait_idle();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grammars();
      test_full_fidelity_bit_packed();
      test_byte_aligned_reads();
      test_random_decodes();
      test_unthrottled_stream();
      error_count += pending_events.size();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
